FILE: rtl/rgb_to_ypbpr_converter_core_macros.svh
// assertion macros for the rgb to ypbpr converter
`ifndef RGB_TO_YPBPR_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_YPBPR_CONVERTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RGBYP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RGBYP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RGBYP_ASSERT(lbl, prop, msg)
`define RGBYP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/rgbyp_pkg.sv
`timescale 1ns / 1ps
package rgbyp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FIELD_W     = 16;
  localparam int NUM_W       = 32;
  localparam int DEN_W       = 16;
  localparam int DIV_STEP    = 4;
  localparam int DIV_STAGES  = NUM_W / DIV_STEP;
  localparam int PIPE_DEPTH  = DIV_STAGES + 3;
  localparam int COEF_W      = 18;
  localparam int PROD_W      = NUM_W + 1 + COEF_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam logic [DEN_W-1:0] MAX_VALUE_RESET = 16'd255;

  // bt.601 matrix in q16, rows y, pb, pr; columns r, g, b
  localparam logic signed [COEF_W-1:0] COEF [3][3] = '{
    '{ 18'sd19595,  18'sd38470,  18'sd7471 },
    '{-18'sd11058, -18'sd21710,  18'sd32768},
    '{ 18'sd32768, -18'sd27439, -18'sd5329 }
  };

  localparam logic signed [SUM_W-1:0] Q32_ONE  = SUM_W'(64'sd1 <<< 32);
  localparam logic signed [SUM_W-1:0] Q32_HALF = SUM_W'(64'sd1 <<< 31);

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic        [FIELD_W-1:0] luma;
    logic signed [FIELD_W-1:0] blue_diff;
    logic signed [FIELD_W-1:0] red_diff;
  } pixel_out_t;

endpackage

FILE: rtl/rgbyp_div.sv
`timescale 1ns / 1ps
module rgbyp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rgbyp_pkg::NUM_W-1:0]   num,
  input  logic [rgbyp_pkg::DEN_W-1:0]   den,
  output logic [rgbyp_pkg::NUM_W-1:0]   quot
);

  logic [rgbyp_pkg::DEN_W-1:0] rem [rgbyp_pkg::DIV_STAGES];
  logic [rgbyp_pkg::NUM_W-1:0] nq  [rgbyp_pkg::DIV_STAGES];

  // DIV_STEP restoring steps; numerator bits shift out as quotient bits shift in
  function automatic logic [rgbyp_pkg::DEN_W+rgbyp_pkg::NUM_W-1:0] div_step(
    input logic [rgbyp_pkg::DEN_W-1:0] rem_in,
    input logic [rgbyp_pkg::NUM_W-1:0] nq_in,
    input logic [rgbyp_pkg::DEN_W-1:0] d
  );
    logic [rgbyp_pkg::DEN_W:0]   r;
    logic [rgbyp_pkg::NUM_W-1:0] q;
    r = {1'b0, rem_in};
    q = nq_in;
    for (int i = 0; i < rgbyp_pkg::DIV_STEP; i++) begin
      r = {r[rgbyp_pkg::DEN_W-1:0], q[rgbyp_pkg::NUM_W-1]};
      q = {q[rgbyp_pkg::NUM_W-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return {r[rgbyp_pkg::DEN_W-1:0], q};
  endfunction

  // one register stage per group of quotient bits
  for (genvar s = 0; s < rgbyp_pkg::DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          {rem[s], nq[s]} <= div_step('0, num, den);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          {rem[s], nq[s]} <= div_step(rem[s-1], nq[s-1], den);
        end
      end
    end
  end

  assign quot = nq[rgbyp_pkg::DIV_STAGES-1];

endmodule

FILE: rtl/rgb_to_ypbpr_converter_core.sv
`timescale 1ns / 1ps
`include "rgb_to_ypbpr_converter_core_macros.svh"
// BT.601 RGB to Y/Pb/Pr converter. Each sample is divided by max_value (0 acts as 1)
// into an unclamped q16 value, multiplied by the q16 matrix, clamped and rounded to
// q1.15. One pixel is taken per clock while the output is not stalled; a request
// passes 11 register stages, the 8-stage divider (4 quotient bits per stage) plus
// the multiply, sum and output stages.
// The whole pipeline holds while the output is stalled.
// max_value may only be written while the pipeline is empty.
module rgb_to_ypbpr_converter_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [15:0]            cfg_write_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rgbyp_pkg::pixel_in_t   in_pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rgbyp_pkg::pixel_out_t  out_pixel
);

  logic [rgbyp_pkg::DEN_W-1:0]      max_value;
  logic [rgbyp_pkg::DEN_W-1:0]      den;
  logic [rgbyp_pkg::PIPE_DEPTH-1:0] vld;
  logic                             adv;
  logic [rgbyp_pkg::NUM_W-1:0]      num [3];
  logic [rgbyp_pkg::NUM_W-1:0]      quot [3];
  logic [rgbyp_pkg::SAMPLE_BITS-1:0] smp [3];
  logic signed [rgbyp_pkg::PROD_W-1:0] prod [3][3];
  logic signed [rgbyp_pkg::SUM_W-1:0]  sum [3];
  logic signed [rgbyp_pkg::SUM_W-1:0]  y_c, pb_c, pr_c;
  logic [rgbyp_pkg::SUM_W-1:0]         y_b, pb_b, pr_b;
  rgbyp_pkg::pixel_out_t               res;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= rgbyp_pkg::MAX_VALUE_RESET;
    end else if (cfg_write_en) begin
      max_value <= cfg_write_data;
    end
  end

  assign den = (max_value == '0) ? rgbyp_pkg::DEN_W'(1) : max_value;

  // pipeline advance and valid bits
  assign adv       = !vld[rgbyp_pkg::PIPE_DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[rgbyp_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[rgbyp_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  // rounded numerators
  assign smp[0] = in_pixel.red[rgbyp_pkg::SAMPLE_BITS-1:0];
  assign smp[1] = in_pixel.green[rgbyp_pkg::SAMPLE_BITS-1:0];
  assign smp[2] = in_pixel.blue[rgbyp_pkg::SAMPLE_BITS-1:0];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign num[c] = (rgbyp_pkg::NUM_W'(smp[c]) << 16)
                  + rgbyp_pkg::NUM_W'(den >> 1);
    rgbyp_div u_div (
      .clk  (clk),
      .en   (adv),
      .num  (num[c]),
      .den  (den),
      .quot (quot[c])
    );
  end

  // matrix products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < 3; o++) begin
        for (int c = 0; c < 3; c++) begin
          prod[o][c] <= $signed({1'b0, quot[c]}) * rgbyp_pkg::COEF[o][c];
        end
      end
    end
  end

  // row sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < 3; o++) begin
        sum[o] <= rgbyp_pkg::SUM_W'(prod[o][0]) + rgbyp_pkg::SUM_W'(prod[o][1])
                + rgbyp_pkg::SUM_W'(prod[o][2]);
      end
    end
  end

  // clamp and round to q1.15
  always_comb begin
    y_c  = (sum[0] < 0) ? '0 : ((sum[0] > rgbyp_pkg::Q32_ONE) ? rgbyp_pkg::Q32_ONE : sum[0]);
    pb_c = (sum[1] < -rgbyp_pkg::Q32_HALF) ? -rgbyp_pkg::Q32_HALF :
           ((sum[1] > rgbyp_pkg::Q32_HALF) ? rgbyp_pkg::Q32_HALF : sum[1]);
    pr_c = (sum[2] < -rgbyp_pkg::Q32_HALF) ? -rgbyp_pkg::Q32_HALF :
           ((sum[2] > rgbyp_pkg::Q32_HALF) ? rgbyp_pkg::Q32_HALF : sum[2]);
    y_b  = unsigned'(y_c) + (rgbyp_pkg::SUM_W'(1) << 16);
    pb_b = unsigned'(pb_c + rgbyp_pkg::Q32_HALF) + (rgbyp_pkg::SUM_W'(1) << 16);
    pr_b = unsigned'(pr_c + rgbyp_pkg::Q32_HALF) + (rgbyp_pkg::SUM_W'(1) << 16);
    res.luma      = y_b[32:17];
    res.blue_diff = $signed(pb_b[32:17] - 16'd16384);
    res.red_diff  = $signed(pr_b[32:17] - 16'd16384);
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel <= res;
    end
  end

  // checks
  `RGBYP_ASSERT(a_luma_range, !out_valid || out_pixel.luma <= 16'd32768, "luma out of range")
  `RGBYP_ASSERT(a_pb_range, !out_valid || (out_pixel.blue_diff <= 16'sd16384 && out_pixel.blue_diff >= -16'sd16384), "pb out of range")
  `RGBYP_ASSERT(a_pr_range, !out_valid || (out_pixel.red_diff <= 16'sd16384 && out_pixel.red_diff >= -16'sd16384), "pr out of range")
  `RGBYP_ASSERT_IMPL(a_stall_keeps, !adv, vld == $past(vld), "pipeline moved during stall")

endmodule
